// File: hw/rtl/sws_pkg.sv
// ----------------------------------------------------------------------------
// Stop-and-wait sender package
// Shared widths, codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package sws_pkg;

  // Default payload size of one frame.
  localparam int PAYLOAD_BYTES_DEF = 8;

  // Field widths.
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 1;

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_PAYLOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EOD     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ACK     = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_NEW      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WRONG    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ACKED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REJECT   = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

  // Byte constants.
  localparam logic [BYTE_W-1:0] ASCII_ZERO      = 8'h30;
  localparam logic [BYTE_W-1:0] TRAILER_RST     = 8'h30;
  localparam logic [BYTE_W-1:0] TIMEOUT_RST     = 8'h58;
  localparam logic [BYTE_W-1:0] PAD_BYTE        = 8'hFF;

  // Output byte source select.
  localparam logic [1:0] SEL_SEQ  = 2'd0;
  localparam logic [1:0] SEL_PAY  = 2'd1;
  localparam logic [1:0] SEL_TRL  = 2'd2;
  localparam logic [1:0] SEL_STAT = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                wr_store;   // write the input byte at the fill position
    logic                fill_inc;
    logic                fill_clr;
    logic                len_full;   // latch a full frame length
    logic                len_fill;   // latch the current fill count as length
    logic                seq_toggle;
    logic                idx_clr;
    logic                idx_inc;
    logic                rd_en;      // fetch the store entry at the next index
    logic                load_out;
    logic [1:0]          out_sel;
    logic [STATUS_W-1:0] out_status;
    logic                out_last;
  } sws_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_last;
    logic ack_match;
    logic ack_timeout;
    logic idx_last;
    logic out_free;
  } sws_stat_t;

endpackage

// File: hw/rtl/sws_in_if.sv
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface sws_in_if
  import sws_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, output cmd, output byte_value, input ready);
  modport sink   (input valid, input cmd, input byte_value, output ready);
endinterface

// File: hw/rtl/sws_out_if.sv
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface sws_out_if
  import sws_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic [STATUS_W-1:0] status;
  logic                last_of_run;

  modport source (output valid, output out_byte, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input status, input last_of_run,
                  output ready);
endinterface

// File: hw/rtl/stop_and_wait_sender.sv
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ sender
// Buffers payload bytes into frames, sends them and handles acks.
//
//   Channel  Direction  Payload
//   in_ch    in         cmd, byte_value
//   out_ch   out        out_byte, status, last_of_run
//   cfg_*    in         cfg_we, cfg_addr, cfg_wdata (trailer, timeout marker)
//
// A payload byte that does not fill the buffer is stored and the block stays
// ready. An item that starts a frame is accepted; the sequencer then sends
// the sequence character, the padded payload and the trailer. A status item
// goes to the status state, which loads its result. Output stalls hold the
// sequencer; the next input item is taken as soon as the last result sits in
// the output register. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module stop_and_wait_sender
  import sws_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sws_in_if.sink               in_ch,
  sws_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  sws_cmd_t  cmd;
  sws_stat_t stat;

  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sws_datapath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_value (in_ch.byte_value),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_byte   (out_ch.out_byte),
    .out_status (out_ch.status),
    .out_last   (out_ch.last_of_run)
  );

endmodule

// File: hw/rtl/sws_datapath.sv
// ----------------------------------------------------------------------------
// Stop-and-wait sender datapath
// Payload store, counters, sequence bit, configuration and result register.
// ----------------------------------------------------------------------------
module sws_datapath
  import sws_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [BYTE_W-1:0]    byte_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  input  sws_cmd_t             cmd,
  output sws_stat_t            stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [BYTE_W-1:0]    out_byte,
  output logic [STATUS_W-1:0]  out_status,
  output logic                 out_last
);

  localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  logic [BYTE_W-1:0]   mem [PAYLOAD_BYTES];
  logic [BYTE_W-1:0]   rd_data_r;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0]    len_r, len_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                seq_r, seq_nxt;
  logic [BYTE_W-1:0]   trailer_r, timeout_r;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_last_r;
  logic [BYTE_W-1:0]   seq_char;
  logic [BYTE_W-1:0]   pay_byte;

  // Character of the current sequence number.
  assign seq_char = ASCII_ZERO | {{(BYTE_W-1){1'b0}}, seq_r};

  // Slots past the frame length read as padding.
  assign pay_byte = (CNT_W'(idx_r) < len_r) ? rd_data_r : PAD_BYTE;

  // Status toward the controller.
  always_comb begin
    stat.fill_last   = (fill_r == CNT_W'(PAYLOAD_BYTES - 1));
    stat.ack_match   = (byte_value == seq_char);
    stat.ack_timeout = (byte_value == timeout_r);
    stat.idx_last    = (idx_r == IDX_W'(PAYLOAD_BYTES - 1));
    stat.out_free    = !out_valid_r || out_ready;
  end

  // Counter and flag updates.
  always_comb begin
    fill_nxt = fill_r;
    if (cmd.fill_clr) begin
      fill_nxt = '0;
    end else if (cmd.fill_inc) begin
      fill_nxt = fill_r + CNT_W'(1);
    end

    len_nxt = len_r;
    if (cmd.len_full) begin
      len_nxt = CNT_W'(PAYLOAD_BYTES);
    end else if (cmd.len_fill) begin
      len_nxt = fill_r;
    end

    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end

    seq_nxt = seq_r ^ cmd.seq_toggle;
  end

  // Result register: loads on command, empties when taken.
  always_comb begin
    unique case (cmd.out_sel)
      SEL_SEQ:  out_byte_nxt = seq_char;
      SEL_PAY:  out_byte_nxt = pay_byte;
      SEL_TRL:  out_byte_nxt = trailer_r;
      SEL_STAT: out_byte_nxt = '0;
      default:  out_byte_nxt = '0;
    endcase
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      len_r       <= '0;
      idx_r       <= '0;
      seq_r       <= 1'b0;
      trailer_r   <= TRAILER_RST;
      timeout_r   <= TIMEOUT_RST;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_TRAILER: trailer_r <= cfg_wdata;
          REG_TIMEOUT: timeout_r <= cfg_wdata;
          default:     trailer_r <= trailer_r;
        endcase
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte_r   <= out_byte_nxt;
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
    end
  end

  // Payload store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_store) begin
      mem[fill_r[IDX_W-1:0]] <= byte_value;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx_nxt];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

// File: hw/rtl/sws_ctrl.sv
// ----------------------------------------------------------------------------
// Stop-and-wait sender controller
// Protocol flags and the sequencer that emits frames and status items.
// ----------------------------------------------------------------------------
module sws_ctrl
  import sws_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  sws_stat_t        stat,
  output sws_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEQ  = 3'd1;
  localparam logic [2:0] S_PAY  = 3'd2;
  localparam logic [2:0] S_TRL  = 3'd3;
  localparam logic [2:0] S_STAT = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] code_r, code_nxt;
  logic                awaiting_r, awaiting_nxt;
  logic                final_r, final_nxt;
  logic                finished_r, finished_nxt;
  logic                accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_ready && in_valid;

  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    awaiting_nxt = awaiting_r;
    final_nxt    = final_r;
    finished_nxt = finished_r;
    cmd          = '0;
    cmd.out_status = code_r;

    unique case (state_r)
      S_IDLE: begin
        // Decide what one accepted item does.
        if (accept) begin
          code_nxt  = ST_REJECT;
          state_nxt = S_STAT;
          cmd.idx_clr = 1'b1;
          priority if ((in_cmd == CMD_PAYLOAD) || (in_cmd == CMD_EOD)) begin
            if (!awaiting_r && !finished_r) begin
              if (in_cmd == CMD_PAYLOAD) begin
                cmd.wr_store = 1'b1;
                if (stat.fill_last) begin
                  cmd.len_full = 1'b1;
                  cmd.fill_clr = 1'b1;
                  awaiting_nxt = 1'b1;
                  code_nxt     = ST_NEW;
                  state_nxt    = S_SEQ;
                end else begin
                  cmd.fill_inc = 1'b1;
                  state_nxt    = S_IDLE;
                end
              end else begin
                cmd.len_fill = 1'b1;
                cmd.fill_clr = 1'b1;
                final_nxt    = 1'b1;
                awaiting_nxt = 1'b1;
                code_nxt     = ST_NEW;
                state_nxt    = S_SEQ;
              end
            end
          end else if (in_cmd == CMD_ACK) begin
            if (awaiting_r && !finished_r) begin
              if (stat.ack_match) begin
                cmd.seq_toggle = 1'b1;
                awaiting_nxt   = 1'b0;
                if (final_r) begin
                  finished_nxt = 1'b1;
                  code_nxt     = ST_COMPLETE;
                end else begin
                  code_nxt     = ST_ACKED;
                end
              end else begin
                code_nxt  = stat.ack_timeout ? ST_TIMEOUT : ST_WRONG;
                state_nxt = S_SEQ;
              end
            end
          end else begin
            code_nxt = ST_REJECT;
          end
        end
      end

      S_SEQ: begin
        // Sequence character; fetch the first payload entry.
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = SEL_SEQ;
          cmd.idx_clr  = 1'b1;
          cmd.rd_en    = 1'b1;
          state_nxt    = S_PAY;
        end
      end

      S_PAY: begin
        // One payload byte per free slot, prefetching the next entry.
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = SEL_PAY;
          if (stat.idx_last) begin
            state_nxt = S_TRL;
          end else begin
            cmd.idx_inc = 1'b1;
            cmd.rd_en   = 1'b1;
          end
        end
      end

      S_TRL: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = SEL_TRL;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      S_STAT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = SEL_STAT;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      code_r     <= ST_NEW;
      awaiting_r <= 1'b0;
      final_r    <= 1'b0;
      finished_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      code_r     <= code_nxt;
      awaiting_r <= awaiting_nxt;
      final_r    <= final_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

// File: sim/stop_and_wait_sender_test.sv
// ----------------------------------------------------------------------------
// Stop-and-wait sender regression
// Feeds payload bytes, end-of-data and ack items through the input channel
// with bursty timing while the result channel stalls on its own pattern.
// A predictor tracks the frame buffer, sequence character and ack handshake,
// and every result item is checked field by field against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stop_and_wait_sender_test;
  import sws_pkg::*;

  localparam int PAYLOAD_BYTES  = PAYLOAD_BYTES_DEF;
  localparam int SETTLE_CYCLES  = PAYLOAD_BYTES + 4;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_ITEMS    = 58;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_SYNC, OP_HOLD} op_kind_t;

  typedef struct {
    op_kind_t             kind;
    logic [CMD_W-1:0]     cmd;
    logic [BYTE_W-1:0]    value;
    logic [CFG_IDX_W-1:0] idx;
  } pending_op_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic [STATUS_W-1:0] status;
    logic                last_of_run;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [BYTE_W-1:0]    cfg_wdata;

  sws_in_if  in_ch ();
  sws_out_if out_ch ();

  stop_and_wait_sender #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Stimulus waiting to be driven and results waiting to be seen.
  pending_op_t   pending_ops[$];
  frame_result_t expected_results[$];
  int            errors = 0;

  // Predicted state of the sender.
  logic [BYTE_W-1:0] frame_buf [PAYLOAD_BYTES];
  int                fill_count  = 0;
  logic              seq_bit     = 1'b0;
  logic              waiting_ack = 1'b0;
  logic              last_frame  = 1'b0;
  logic              session_done = 1'b0;
  logic [BYTE_W-1:0] trailer_reg = TRAILER_RST;
  logic [BYTE_W-1:0] timeout_reg = TIMEOUT_RST;

  // State the stimulus generator keeps so that its sequences stay well formed.
  int                gen_fill    = 0;
  logic              gen_seq     = 1'b0;
  logic              gen_wait    = 1'b0;
  logic              gen_final   = 1'b0;
  logic              gen_done    = 1'b0;
  logic [BYTE_W-1:0] gen_timeout = TIMEOUT_RST;
  int                n_items     = 0;

  // Driver and receiver pacing.
  int burst_left  = 1;
  int gap_left    = 0;
  int settle_left = SETTLE_CYCLES;
  int hold_reqs   = 0;
  int holds_done  = 0;
  int hold_left   = 0;
  int rx_cycle    = 0;
  int rx_mode     = 0;
  int rx_run_left = 0;
  logic rx_run_level = 1'b0;
  int idle_cycles = 0;

  logic [BYTE_W-1:0] corner_bytes [PAYLOAD_BYTES] =
    '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic expect_status(input logic [STATUS_W-1:0] st);
    expected_results.push_back('{out_byte: '0, status: st, last_of_run: 1'b1});
  endtask

  // A frame is the sequence character, the stored payload, then the trailer.
  task automatic expect_frame(input logic [STATUS_W-1:0] st);
    expected_results.push_back('{out_byte: ASCII_ZERO + BYTE_W'(seq_bit), status: st,
                                 last_of_run: 1'b0});
    for (int i = 0; i < PAYLOAD_BYTES; i++)
      expected_results.push_back('{out_byte: frame_buf[i], status: st, last_of_run: 1'b0});
    expected_results.push_back('{out_byte: trailer_reg, status: st, last_of_run: 1'b1});
  endtask

  task automatic predict_item(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] v);
    case (c)
      CMD_PAYLOAD, CMD_EOD: begin
        if (waiting_ack || session_done) begin
          expect_status(ST_REJECT);
        end else if (c == CMD_PAYLOAD && fill_count < PAYLOAD_BYTES - 1) begin
          frame_buf[fill_count] = v;
          fill_count++;
        end else begin
          // Either the last free slot is filled or end of data pads the rest.
          if (c == CMD_PAYLOAD) begin
            frame_buf[PAYLOAD_BYTES-1] = v;
          end else begin
            for (int i = fill_count; i < PAYLOAD_BYTES; i++) frame_buf[i] = PAD_BYTE;
            last_frame = 1'b1;
          end
          fill_count  = 0;
          waiting_ack = 1'b1;
          expect_frame(ST_NEW);
        end
      end
      CMD_ACK: begin
        if (!waiting_ack || session_done) begin
          expect_status(ST_REJECT);
        end else if (v == ASCII_ZERO + BYTE_W'(seq_bit)) begin
          // A matching ack wins even when it equals the timeout marker.
          seq_bit     = ~seq_bit;
          waiting_ack = 1'b0;
          if (last_frame) begin
            session_done = 1'b1;
            expect_status(ST_COMPLETE);
          end else begin
            expect_status(ST_ACKED);
          end
        end else if (v == timeout_reg) begin
          expect_frame(ST_TIMEOUT);
        end else begin
          expect_frame(ST_WRONG);
        end
      end
      default: expect_status(ST_REJECT);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  task automatic push_item(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] v);
    pending_ops.push_back('{kind: OP_ITEM, cmd: c, value: v, idx: '0});
    n_items++;
    if (!gen_done) begin
      if (c == CMD_PAYLOAD && !gen_wait) begin
        gen_fill++;
        if (gen_fill == PAYLOAD_BYTES) begin
          gen_fill = 0;
          gen_wait = 1'b1;
        end
      end else if (c == CMD_EOD && !gen_wait) begin
        gen_fill  = 0;
        gen_wait  = 1'b1;
        gen_final = 1'b1;
      end else if (c == CMD_ACK && gen_wait && v == ASCII_ZERO + BYTE_W'(gen_seq)) begin
        gen_seq  = ~gen_seq;
        gen_wait = 1'b0;
        if (gen_final) gen_done = 1'b1;
      end
    end
  endtask

  task automatic push_sync();
    pending_ops.push_back('{kind: OP_SYNC, cmd: '0, value: '0, idx: '0});
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
    pending_ops.push_back('{kind: OP_CFG, cmd: '0, value: v, idx: idx});
    if (idx == REG_TIMEOUT) gen_timeout = v;
  endtask

  // Fill the buffer with random payload until a frame goes out.
  task automatic push_frame();
    while (!gen_wait && !gen_done) push_item(CMD_PAYLOAD, BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic push_good_ack();
    push_item(CMD_ACK, ASCII_ZERO + BYTE_W'(gen_seq));
  endtask

  // An ack that asks for a resend, either the timeout marker or a wrong byte.
  task automatic push_bad_ack(input bit use_timeout);
    logic [BYTE_W-1:0] v;
    if (use_timeout) begin
      v = gen_timeout;
    end else begin
      do v = BYTE_W'($urandom_range(0, 255));
      while (v == ASCII_ZERO + BYTE_W'(gen_seq) || v == gen_timeout);
    end
    push_item(CMD_ACK, v);
  endtask

  // Items that arrive out of turn and are rejected.
  task automatic push_noise();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) begin
      push_item(CMD_UNUSED, BYTE_W'($urandom_range(0, 255)));
    end else if (!gen_wait) begin
      push_item(CMD_ACK, BYTE_W'($urandom_range(0, 255)));
    end else begin
      push_item((pick == 1) ? CMD_PAYLOAD : CMD_EOD, BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: input channel, configuration port and sender pauses
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    pending_op_t          op;
    logic                 nv;
    logic [CMD_W-1:0]     nc;
    logic [BYTE_W-1:0]    nb;
    logic                 nwe;
    logic [CFG_IDX_W-1:0] na;
    logic [BYTE_W-1:0]    nd;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      cfg_we      <= 1'b0;
    end else begin
      nv  = in_ch.valid;
      nc  = in_ch.cmd;
      nb  = in_ch.byte_value;
      nwe = 1'b0;
      na  = cfg_addr;
      nd  = cfg_wdata;
      // An accepted item updates the prediction in acceptance order.
      if (in_ch.valid && in_ch.ready) begin
        predict_item(in_ch.cmd, in_ch.byte_value);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops[0];
          case (op.kind)
            OP_ITEM: begin
              nv = 1'b1;
              nc = op.cmd;
              nb = op.value;
              void'(pending_ops.pop_front());
              if (burst_left > 1) begin
                burst_left--;
              end else if ($urandom_range(0, 7) == 0) begin
                burst_left = 40;
                gap_left   = 0;
              end else begin
                burst_left = $urandom_range(1, 12);
                gap_left   = $urandom_range(1, 6);
              end
            end
            OP_CFG: begin
              nwe = 1'b1;
              na  = op.idx;
              nd  = op.value;
              if (op.idx == REG_TRAILER) trailer_reg = op.value;
              else timeout_reg = op.value;
              void'(pending_ops.pop_front());
            end
            OP_SYNC: begin
              // Wait for every result, then let the block finish any work.
              if (expected_results.size() != 0) begin
                settle_left = SETTLE_CYCLES;
              end else if (settle_left > 0) begin
                settle_left--;
              end else begin
                settle_left = SETTLE_CYCLES;
                void'(pending_ops.pop_front());
              end
            end
            default: begin
              hold_reqs <= hold_reqs + 1;
              void'(pending_ops.pop_front());
            end
          endcase
        end
      end
      in_ch.valid      <= nv;
      in_ch.cmd        <= nc;
      in_ch.byte_value <= nb;
      cfg_we           <= nwe;
      cfg_addr         <= na;
      cfg_wdata        <= nd;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: result checking and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : recv_proc
    frame_result_t got;
    frame_result_t want;
    logic          rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_byte: out_ch.out_byte, status: out_ch.status,
                last_of_run: out_ch.last_of_run};
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: byte %02h status %0d last %0b",
                                 got.out_byte, got.status, got.last_of_run));
        end else begin
          want = expected_results.pop_front();
          if (got.out_byte !== want.out_byte || got.status !== want.status ||
              got.last_of_run !== want.last_of_run)
            note_failure($sformatf(
              "mismatch: expected byte %02h status %0d last %0b, got byte %02h status %0d last %0b",
              want.out_byte, want.status, want.last_of_run,
              got.out_byte, got.status, got.last_of_run));
        end
      end

      // The stall pattern changes character on a period counted by rx_cycle.
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (holds_done != hold_reqs) begin
        holds_done++;
        hold_left = LONG_HOLD;
        rdy = 1'b0;
      end else begin
        case (rx_mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 9) < 6);
          default: begin
            if (rx_run_left == 0) begin
              rx_run_level = ~rx_run_level;
              rx_run_left  = $urandom_range(1, 8);
            end
            rx_run_left--;
            rdy = rx_run_level;
          end
        endcase
      end
      out_ch.ready <= rdy;
    end
  end

  // Watchdog: a long stretch with no item moving anywhere ends the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : main_proc
    logic [BYTE_W-1:0] trailer_set [4];
    logic [BYTE_W-1:0] timeout_set [4];
    int start;
    int pick;
    int extra;

    in_ch.valid      = 1'b0;
    in_ch.cmd        = '0;
    in_ch.byte_value = '0;
    out_ch.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_addr         = '0;
    cfg_wdata        = '0;
    rst_n            = 1'b0;

    // Directed part, default registers: rejects while filling, a full frame
    // of corner bytes, rejects while waiting, both resend kinds, then an ack.
    push_item(CMD_ACK, 8'h00);
    push_item(CMD_UNUSED, 8'hFF);
    foreach (corner_bytes[k]) push_item(CMD_PAYLOAD, corner_bytes[k]);
    push_item(CMD_PAYLOAD, 8'h12);
    push_item(CMD_EOD, 8'h00);
    push_bad_ack(1'b1);
    push_item(CMD_ACK, ASCII_ZERO + BYTE_W'(!gen_seq));
    push_good_ack();

    // The timeout marker equals the next sequence character, so the ack
    // must count as a match rather than a timeout.
    push_sync();
    push_cfg(REG_TRAILER, 8'h00);
    push_cfg(REG_TIMEOUT, ASCII_ZERO + BYTE_W'(gen_seq));
    push_frame();
    push_bad_ack(1'b1);

    // Random phases, each under its own register setting.
    trailer_set = '{8'hFF, 8'h00, BYTE_W'($urandom_range(0, 255)), TRAILER_RST};
    timeout_set = '{8'h00, 8'hFF, BYTE_W'($urandom_range(0, 255)), TIMEOUT_RST};
    for (int phase = 0; phase < 4; phase++) begin
      push_sync();
      push_cfg(REG_TRAILER, trailer_set[phase]);
      push_cfg(REG_TIMEOUT, timeout_set[phase]);
      if (phase == 1)
        pending_ops.push_back('{kind: OP_HOLD, cmd: '0, value: '0, idx: '0});
      start = n_items;
      while (n_items - start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          push_frame();
          repeat ($urandom_range(0, 2)) push_bad_ack($urandom_range(0, 1));
          push_good_ack();
        end else if (pick < 9) begin
          push_noise();
        end else begin
          // A partial buffer, to be completed by a later frame.
          repeat ($urandom_range(1, PAYLOAD_BYTES - 1))
            if (!gen_wait) push_item(CMD_PAYLOAD, BYTE_W'($urandom_range(0, 255)));
        end
      end
      if (gen_wait) push_good_ack();
    end

    // Final frame: sometimes from an emptied buffer, otherwise after a random top-up short of full.
    push_sync();
    push_cfg(REG_TRAILER, BYTE_W'($urandom_range(0, 255)));
    push_cfg(REG_TIMEOUT, BYTE_W'($urandom_range(0, 255)));
    if (gen_fill != 0 && $urandom_range(0, 2) == 0) begin
      push_frame();
      push_good_ack();
    end else begin
      extra = $urandom_range(0, PAYLOAD_BYTES - 1 - gen_fill);
      repeat (extra) push_item(CMD_PAYLOAD, BYTE_W'($urandom_range(0, 255)));
    end
    push_item(CMD_EOD, BYTE_W'($urandom_range(0, 255)));
    push_bad_ack(1'b1);
    push_bad_ack(1'b0);
    push_item(CMD_PAYLOAD, BYTE_W'($urandom_range(0, 255)));
    push_item(CMD_EOD, BYTE_W'($urandom_range(0, 255)));
    push_good_ack();

    // After completion everything is rejected.
    push_item(CMD_PAYLOAD, BYTE_W'($urandom_range(0, 255)));
    push_item(CMD_EOD, BYTE_W'($urandom_range(0, 255)));
    push_good_ack();
    push_item(CMD_UNUSED, BYTE_W'($urandom_range(0, 255)));

    // Reset, then let the driver work through the queue.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_ops.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", expected_results.size()));

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
